### hw/rtl/twsa_pkg.sv
// ---------------------------------------------------------------------------
// twsa_pkg
// Shared types, constants and tables of the terrain wind slope adjust block.
// ---------------------------------------------------------------------------
package twsa_pkg;

  // Angles are Q16 degrees, signed.
  localparam int ANG_W = 26;
  localparam logic signed [ANG_W-1:0] RIGHT_ANGLE = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] HALF_TURN   = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] FULL_TURN   = 26'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG5        = 26'sd327680;
  localparam logic signed [ANG_W-1:0] DEG10       = 26'sd655360;
  localparam logic [14:0]             DIR_UNITS   = 15'd23040;
  localparam logic [16:0]             QONE        = 17'd65536;

  localparam int CORDIC_STEPS = 23;
  localparam int CW           = 46;
  localparam int NORM_W       = 42;
  localparam int MAG_W        = 30;
  localparam int ISQ_W        = 62;
  localparam int ROOT_W       = 31;
  localparam int ISQ_STEPS    = 31;
  localparam int GRAD_STAGES  = 5;
  localparam int TWSA_LATENCY = GRAD_STAGES + ISQ_STEPS + 2 + CORDIC_STEPS + 2
                                + CORDIC_STEPS + 6;

  localparam logic [22:0] ATAN_TAB [CORDIC_STEPS] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2, 23'd1
  };

  // Roughness factor per cover class, Q16; class 3 acts as brush
  localparam logic [15:0] ROUGH_TAB [4] = '{16'd65339, 16'd63570, 16'd55706, 16'd63570};

  typedef enum logic [1:0] {
    REG_SPEED = 2'd0,
    REG_DIR   = 2'd1,
    REG_CELL  = 2'd2,
    REG_VEG   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]       k;
    logic [1:0]       sh;
    logic             flat;
    logic [MAG_W-1:0] ua;
    logic [MAG_W-1:0] ub;
    logic             an;
    logic             bn;
    logic             border;
  } grad_side_t;

  // Left shift that brings a nonzero value up to at least 2^40
  function automatic logic [5:0] norm_shift(input logic [NORM_W-1:0] mx);
    logic [5:0] s;
    s = 6'd0;
    for (int i = 1; i <= 40; i++) begin
      if ((mx >> (41 - i)) == '0) s = 6'(i);
    end
    return s;
  endfunction

endpackage

### hw/rtl/terrain_wind_slope_adjust.sv
// ---------------------------------------------------------------------------
// terrain_wind_slope_adjust
// Per-cell wind speed and direction adjustment from terrain slope and aspect.
// ---------------------------------------------------------------------------
// Pipeline from start to done: gradient 5, square root 31, CORDIC atan 23,
//   cos 23, glue and output 10 stages.
// Throughput: one word per cycle; busy stays low, every stage advances each
//   cycle and the result is shown for one cycle on done.
// Reset: synchronous rst clears the valid bits of every stage and loads the
//   configuration registers with their reset values.
module terrain_wind_slope_adjust #(
  parameter int ELEVATION_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_east,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_west,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_north,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_south,
  input  logic                              is_edge,
  output logic                              done,
  output logic [16:0]                       speed_out,
  output logic [14:0]                       direction_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import twsa_pkg::*;

  // Side data carried through the cos CORDIC
  typedef struct packed {
    logic              neg;
    logic [16:0]       f;
    logic signed [ANG_W-1:0] diff;
    logic              gt5;
    logic              gt10;
    logic              border;
  } cos_side_t;

  localparam logic [23:0] RECIP45 = 24'd11930465;   // ceil(2^29 / 45)
  localparam logic [17:0] RECIP5  = 18'd209716;     // ceil(2^20 / 5)
  localparam logic [26:0] RECIP10 = 27'd107374183;  // ceil(2^30 / 10)
  localparam logic signed [CW-1:0] COS_GAIN = 46'sd652032875;

  // ---------------- configuration registers ----------------
  logic [15:0] wind_speed;
  logic [14:0] wind_direction;
  logic [23:0] cell_size;
  logic [1:0]  vegetation;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_speed     <= 16'd2560;
      wind_direction <= 15'd0;
      cell_size      <= 24'd256;
      vegetation     <= 2'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPEED: wind_speed     <= pwdata[15:0];
        REG_DIR:   wind_direction <= pwdata[14:0];
        REG_CELL:  cell_size      <= pwdata[23:0];
        REG_VEG:   vegetation     <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPEED: prdata = 32'(wind_speed);
      REG_DIR:   prdata = 32'(wind_direction);
      REG_CELL:  prdata = 32'(cell_size);
      REG_VEG:   prdata = 32'(vegetation);
    endcase
  end

  // Wind direction folded into one turn, and in Q16 degrees
  logic [14:0]             wd;
  logic signed [ANG_W-1:0] wq;
  logic [23:0]             csz;

  assign wd   = (wind_direction >= DIR_UNITS) ? 15'(wind_direction - DIR_UNITS)
                                              : wind_direction;
  assign wq   = $signed({1'b0, wd, 10'b0});
  assign csz  = (cell_size == '0) ? 24'd1 : cell_size;
  assign busy = 1'b0;

  // ---------------- gradient and square root ----------------
  logic        g_valid;
  logic [61:0] g_ss;
  grad_side_t  g_side;

  twsa_grad #(
    .ELEVATION_WIDTH(ELEVATION_WIDTH)
  ) u_grad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .elev_east (elev_east),
    .elev_west (elev_west),
    .elev_north(elev_north),
    .elev_south(elev_south),
    .is_edge   (is_edge),
    .cell_size (cell_size),
    .out_valid (g_valid),
    .ss        (g_ss),
    .side      (g_side)
  );

  logic              q_valid;
  logic [ROOT_W-1:0] q_root;
  grad_side_t        q_side;

  twsa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (g_valid),
    .v        (g_ss),
    .side_in  (g_side),
    .out_valid(q_valid),
    .root     (q_root),
    .side_out (q_side)
  );

  // ---------------- P1: undo the scaling on the rise/run pair ----------------
  logic              p1_valid;
  logic [NORM_W-1:0] p1_hyp, p1_d, hyp_next, d_next;
  logic [MAG_W-1:0]  p1_ua, p1_ub;
  logic              p1_an, p1_bn, p1_flat, p1_border;

  always_comb begin
    if (q_side.k >= 5'(q_side.sh)) begin
      hyp_next = NORM_W'(q_root);
      d_next   = NORM_W'({csz, 1'b0}) << (q_side.k - 5'(q_side.sh));
    end else begin
      hyp_next = NORM_W'(q_root) << (5'(q_side.sh) - q_side.k);
      d_next   = NORM_W'({csz, 1'b0});
    end
  end

  // ---------------- P2: bring both CORDIC operand pairs to full scale ----------------
  logic                 p2_valid;
  logic signed [CW-1:0] p2_xs, p2_ys, p2_xa, p2_ya;
  logic                 p2_an, p2_bn, p2_flat, p2_border;
  logic [NORM_W-1:0]    mx_s, mx_a;
  logic [5:0]           ns_s, ns_a;

  assign mx_s = (p1_hyp > p1_d) ? p1_hyp : p1_d;
  assign mx_a = (p1_ua > p1_ub) ? NORM_W'(p1_ua) : NORM_W'(p1_ub);
  assign ns_s = norm_shift(mx_s);
  assign ns_a = norm_shift(mx_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= q_valid;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_hyp    <= hyp_next;
    p1_d      <= d_next;
    p1_ua     <= q_side.ua;
    p1_ub     <= q_side.ub;
    p1_an     <= q_side.an;
    p1_bn     <= q_side.bn;
    p1_flat   <= q_side.flat;
    p1_border <= q_side.border;
    p2_xs     <= $signed(CW'(p1_d << ns_s));
    p2_ys     <= $signed(CW'(p1_hyp << ns_s));
    p2_xa     <= $signed(CW'(NORM_W'(p1_ub) << ns_a));
    p2_ya     <= $signed(CW'(NORM_W'(p1_ua) << ns_a));
    p2_an     <= p1_an;
    p2_bn     <= p1_bn;
    p2_flat   <= p1_flat;
    p2_border <= p1_border;
  end

  // ---------------- slope and aspect angles ----------------
  logic                    vs_valid, va_valid;
  logic signed [CW-1:0]    vs_x, vs_y, va_x, va_y;
  logic signed [ANG_W-1:0] vs_z, va_z;
  logic [1:0]              vs_side, va_side;

  twsa_cordic #(
    .SIDE_W(2),
    .ROTATE(1'b0)
  ) u_slope (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p2_valid),
    .x_in     (p2_xs),
    .y_in     (p2_ys),
    .z_in     ('0),
    .side_in  ({p2_flat, p2_border}),
    .out_valid(vs_valid),
    .x_out    (vs_x),
    .y_out    (vs_y),
    .z_out    (vs_z),
    .side_out (vs_side)
  );

  twsa_cordic #(
    .SIDE_W(2),
    .ROTATE(1'b0)
  ) u_aspect (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p2_valid),
    .x_in     (p2_xa),
    .y_in     (p2_ya),
    .z_in     ('0),
    .side_in  ({p2_an, p2_bn}),
    .out_valid(va_valid),
    .x_out    (va_x),
    .y_out    (va_y),
    .z_out    (va_z),
    .side_out (va_side)
  );

  // ---------------- F1: clamp angles, compass aspect, slope factor ----------------
  logic                    f1_valid, f1_border;
  logic signed [ANG_W-1:0] f1_slope, f1_aspect;
  logic [16:0]             f1_f;
  logic signed [ANG_W-1:0] slope_c, phi_c, comp;
  logic [46:0]             fprod;
  logic [17:0]             fq;

  always_comb begin
    slope_c = vs_z;
    if (vs_z < 0) slope_c = '0;
    if (vs_z > RIGHT_ANGLE) slope_c = RIGHT_ANGLE;
    phi_c = va_z;
    if (va_z < 0) phi_c = '0;
    if (va_z > RIGHT_ANGLE) phi_c = RIGHT_ANGLE;
    // east sign picks the half, north sign the quarter
    if (!va_side[1]) begin
      comp = va_side[0] ? HALF_TURN - phi_c : phi_c;
    end else begin
      comp = va_side[0] ? HALF_TURN + phi_c : FULL_TURN - phi_c;
    end
    if (comp >= FULL_TURN) comp = comp - FULL_TURN;
    fprod = 47'(slope_c[22:0]) * 47'(RECIP45);
    fq    = 18'(fprod >> 29);
  end

  // ---------------- F2: fold the cos argument, signed aspect offset ----------------
  logic                    f2_valid;
  logic signed [ANG_W-1:0] f2_ang;
  cos_side_t               f2_side;
  logic signed [ANG_W-1:0] delta, fold, dif;

  always_comb begin
    delta = wq - f1_aspect;
    fold  = delta[ANG_W-1] ? -delta : delta;
    if (fold > HALF_TURN) fold = FULL_TURN - fold;
    dif = f1_aspect - wq;
    if (dif > HALF_TURN) begin
      dif = dif - FULL_TURN;
    end else if (dif < -HALF_TURN) begin
      dif = dif + FULL_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      f1_valid <= vs_valid && va_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_slope  <= slope_c;
    f1_aspect <= vs_side[1] ? '0 : comp;
    f1_f      <= (fq > 18'(QONE)) ? QONE : 17'(fq);
    f1_border <= vs_side[0];
    if (fold <= RIGHT_ANGLE) begin
      f2_ang      <= fold;
      f2_side.neg <= 1'b0;
    end else begin
      f2_ang      <= HALF_TURN - fold;
      f2_side.neg <= 1'b1;
    end
    f2_side.f      <= f1_f;
    f2_side.diff   <= dif;
    f2_side.gt5    <= f1_slope > DEG5;
    f2_side.gt10   <= f1_slope > DEG10;
    f2_side.border <= f1_border;
  end

  // ---------------- cosine ----------------
  logic                    cr_valid;
  logic signed [CW-1:0]    cr_x, cr_y;
  logic signed [ANG_W-1:0] cr_z;
  cos_side_t               cr_side;

  twsa_cordic #(
    .SIDE_W($bits(cos_side_t)),
    .ROTATE(1'b1)
  ) u_cos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f2_valid),
    .x_in     (COS_GAIN),
    .y_in     ('0),
    .z_in     (f2_ang),
    .side_in  (f2_side),
    .out_valid(cr_valid),
    .x_out    (cr_x),
    .y_out    (cr_y),
    .z_out    (cr_z),
    .side_out (cr_side)
  );

  // ---------------- C1..C5: speed modifier and deflection ----------------
  logic                 c1_valid, c2_valid, c3_valid, c4_valid, c5_valid;
  logic [4:0]           bord;
  logic [2:0]           g5, g10;
  logic signed [CW-1:0] crnd;
  logic signed [17:0]   cclip, c1_c;
  logic signed [43:0]   diff_w, f_w, c1_prod, p3;
  logic [16:0]          c1_f;
  logic signed [34:0]   t_next, c2_t;
  logic [25:0]          c2_dabs;
  logic                 c2_dneg;
  logic [17:0]          tabs;
  logic [35:0]          qm_prod;
  logic [52:0]          qd_prod;
  logic [14:0]          c3_qm;
  logic [22:0]          c3_qd;
  logic                 c3_tneg, c3_dneg;
  logic signed [18:0]   mod_raw;
  logic [16:0]          mod_next, c4_mod;
  logic signed [ANG_W-1:0] dir_next, c4_dir, dwrap, dround;
  logic [33:0]          m2_prod;
  logic [16:0]          c5_mod2;
  logic [14:0]          dir_q, c5_d64;
  logic [32:0]          sp_prod;
  logic [16:0]          sp_q;

  always_comb begin
    crnd  = (cr_x + CW'(8192)) >>> 14;
    cclip = 18'(crnd);
    if (crnd > CW'(65536)) cclip = 18'sd65536;
    if (crnd < -CW'(65536)) cclip = -18'sd65536;
    diff_w = 44'(cr_side.diff);
    f_w    = $signed(44'({1'b0, cr_side.f}));
  end

  always_comb begin
    t_next = 35'(c1_c) * $signed(35'({1'b0, c1_f}));
    p3     = c1_prod + (c1_prod <<< 1);
  end

  always_comb begin
    tabs    = c2_t[34] ? 18'(35'(-c2_t) >> 15) : 18'(c2_t >> 15);
    qm_prod = 36'(tabs) * 36'(RECIP5);
    qd_prod = 53'(c2_dabs) * 53'(RECIP10);
  end

  // slope thresholds travel beside the C3 values
  always_comb begin
    mod_raw = 19'(QONE) - (c3_tneg ? -19'(c3_qm) : 19'(c3_qm));
    if (!g5[2]) begin
      mod_next = QONE;
    end else if (mod_raw < 19'sd32768) begin
      mod_next = 17'd32768;
    end else if (mod_raw > 19'sd98304) begin
      mod_next = 17'd98304;
    end else begin
      mod_next = 17'(mod_raw);
    end
    dir_next = wq;
    if (g10[2]) begin
      dir_next = c3_dneg ? wq - ANG_W'(c3_qd) : wq + ANG_W'(c3_qd);
    end
  end

  always_comb begin
    m2_prod = 34'(c4_mod) * 34'(ROUGH_TAB[vegetation]) + 34'd32768;
    dwrap   = c4_dir;
    if (c4_dir < 0) dwrap = c4_dir + FULL_TURN;
    if (c4_dir >= FULL_TURN) dwrap = c4_dir - FULL_TURN;
    dround  = (dwrap + ANG_W'(512)) >>> 10;
    dir_q   = 15'(dround);
    if (dir_q >= DIR_UNITS) dir_q = 15'(dir_q - DIR_UNITS);
    sp_prod = 33'(wind_speed) * 33'(c5_mod2) + 33'd32768;
    sp_q    = 17'(sp_prod >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
      c4_valid <= 1'b0;
      c5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      c1_valid <= cr_valid;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
      c4_valid <= c3_valid;
      c5_valid <= c4_valid;
      done     <= c5_valid;
    end
  end

  always_ff @(posedge clk) begin
    // C1: cosine with its sign, raw deflection product
    c1_c    <= cr_side.neg ? -cclip : cclip;
    c1_prod <= diff_w * f_w;
    c1_f    <= cr_side.f;
    g5[0]   <= cr_side.gt5;
    g10[0]  <= cr_side.gt10;
    bord[0] <= cr_side.border;
    // C2: cos times slope factor, deflection magnitude over 2^16
    c2_t    <= t_next;
    c2_dneg <= p3[43];
    c2_dabs <= p3[43] ? 26'(44'(-p3) >> 16) : 26'(p3 >> 16);
    // C3: divide by 5 and by 10 through reciprocals
    c3_qm   <= 15'(qm_prod >> 20);
    c3_tneg <= c2_t[34];
    c3_qd   <= 23'(qd_prod >> 30);
    c3_dneg <= c2_dneg;
    // C4: clamp the modifier, deflect the direction
    c4_mod  <= mod_next;
    c4_dir  <= dir_next;
    // C5: roughness, wrap and round the direction
    c5_mod2 <= 17'(m2_prod >> 16);
    c5_d64  <= dir_q;
    g5[2:1]   <= g5[1:0];
    g10[2:1]  <= g10[1:0];
    bord[4:1] <= bord[3:0];
    // output: border cells pass the wind through
    if (bord[4]) begin
      speed_out     <= 17'(wind_speed);
      direction_out <= wd;
    end else begin
      speed_out     <= sp_q;
      direction_out <= c5_d64;
    end
  end

endmodule

### hw/rtl/twsa_grad.sv
// ---------------------------------------------------------------------------
// twsa_grad
// Gradient front end: differences, scaling, sum of squares, flat test.
// ---------------------------------------------------------------------------
module twsa_grad #(
  parameter int ELEVATION_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_east,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_west,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_north,
  input  logic signed [ELEVATION_WIDTH-1:0] elev_south,
  input  logic                              is_edge,
  input  logic [23:0]                       cell_size,
  output logic                              out_valid,
  output logic [61:0]                       ss,
  output twsa_pkg::grad_side_t              side
);
  import twsa_pkg::*;

  localparam int DW = ELEVATION_WIDTH + 1;

  logic signed [DW-1:0] da, db;
  logic [DW-1:0]        ma, mb, mx;
  logic [1:0]           sh0;
  logic [23:0]          csz;
  logic [49:0]          cs_sq4;

  logic [4:0]       vld;
  logic [MAG_W-1:0] ua1, ub1, ua2, ub2, ua3, ub3, ua4, ub4;
  logic [1:0]       sh1, sh2, sh3, sh4;
  logic [3:0]       an, bn, bord;
  logic [59:0]      sqa, sqb;
  logic [60:0]      s3;
  logic [61:0]      ss4;
  logic [4:0]       k4, k4_next;
  logic             tiny4;
  logic [51:0]      p4;

  assign da  = DW'(elev_east) - DW'(elev_west);
  assign db  = DW'(elev_north) - DW'(elev_south);
  assign ma  = da[DW-1] ? DW'(-da) : DW'(da);
  assign mb  = db[DW-1] ? DW'(-db) : DW'(db);
  assign mx  = (ma > mb) ? ma : mb;
  assign csz = (cell_size == '0) ? 24'd1 : cell_size;

  always_comb begin
    sh0 = 2'd0;
    for (int i = 1; i <= 3; i++) begin
      if ((34'(mx) >> (29 + i)) != '0) sh0 = 2'(i);
    end
  end

  always_comb begin
    k4_next = 5'd16;
    for (int j = 15; j >= 0; j--) begin
      if (s3 >= (61'(1) << (60 - 2 * j))) k4_next = 5'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    cs_sq4 <= {48'(csz) * 48'(csz), 2'b00};
    // scale down together, square, sum
    ua1 <= MAG_W'(34'(ma) >> sh0);
    ub1 <= MAG_W'(34'(mb) >> sh0);
    sh1 <= sh0;
    an[0] <= da[DW-1];
    bn[0] <= db[DW-1];
    bord[0] <= is_edge;
    sqa <= 60'(ua1) * 60'(ua1);
    sqb <= 60'(ub1) * 60'(ub1);
    ua2 <= ua1; ub2 <= ub1; sh2 <= sh1;
    s3  <= 61'(sqa) + 61'(sqb);
    ua3 <= ua2; ub3 <= ub2; sh3 <= sh2;
    // normalize for the root, test for flat cells
    k4    <= k4_next;
    ss4   <= 62'(s3) << (2 * k4_next);
    tiny4 <= (s3 <= 61'(1) << 24);
    p4    <= 52'(s3[24:0]) * 52'(100000000);
    ua4 <= ua3; ub4 <= ub3; sh4 <= sh3;
    an[3:1]   <= an[2:0];
    bn[3:1]   <= bn[2:0];
    bord[3:1] <= bord[2:0];
    ss          <= ss4;
    side.k      <= k4;
    side.sh     <= sh4;
    side.flat   <= (sh4 == 2'd0) && tiny4 && (p4 <= 52'(cs_sq4));
    side.ua     <= ua4;
    side.ub     <= ub4;
    side.an     <= an[3];
    side.bn     <= bn[3];
    side.border <= bord[3];
  end

  assign out_valid = vld[4];

endmodule

### hw/rtl/twsa_isqrt.sv
// ---------------------------------------------------------------------------
// twsa_isqrt
// Pipelined floor square root, one result bit per stage.
// ---------------------------------------------------------------------------
module twsa_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [61:0]          v,
  input  twsa_pkg::grad_side_t side_in,
  output logic                 out_valid,
  output logic [30:0]          root,
  output twsa_pkg::grad_side_t side_out
);
  import twsa_pkg::*;

  logic [ISQ_STEPS-1:0] vld;
  logic [32:0]          rem  [ISQ_STEPS];
  logic [ROOT_W-1:0]    rt   [ISQ_STEPS];
  logic [ISQ_W-1:0]     rest [ISQ_STEPS];
  grad_side_t           sd   [ISQ_STEPS];

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_step
    logic [32:0]       rem_i;
    logic [ROOT_W-1:0] rt_i;
    logic [ISQ_W-1:0]  v_i;
    grad_side_t        sd_i;
    logic              vld_i;
    logic [34:0]       rem_n, trial;

    if (g == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign v_i   = v;
      assign sd_i  = side_in;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem[g-1];
      assign rt_i  = rt[g-1];
      assign v_i   = rest[g-1];
      assign sd_i  = sd[g-1];
      assign vld_i = vld[g-1];
    end

    assign rem_n = {rem_i, v_i[ISQ_W-1:ISQ_W-2]};
    assign trial = {2'b00, rt_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rem_n >= trial) begin
        rem[g] <= 33'(rem_n - trial);
        rt[g]  <= {rt_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem[g] <= 33'(rem_n);
        rt[g]  <= {rt_i[ROOT_W-2:0], 1'b0};
      end
      rest[g] <= v_i << 2;
      sd[g]   <= sd_i;
    end
  end

  assign out_valid = vld[ISQ_STEPS-1];
  assign root      = rt[ISQ_STEPS-1];
  assign side_out  = sd[ISQ_STEPS-1];

endmodule

### hw/rtl/twsa_cordic.sv
// ---------------------------------------------------------------------------
// twsa_cordic
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation.
// ---------------------------------------------------------------------------
module twsa_cordic #(
  parameter int SIDE_W = 1,
  parameter bit ROTATE = 1'b0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [twsa_pkg::CW-1:0]    x_in,
  input  logic signed [twsa_pkg::CW-1:0]    y_in,
  input  logic signed [twsa_pkg::ANG_W-1:0] z_in,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic signed [twsa_pkg::CW-1:0]    x_out,
  output logic signed [twsa_pkg::CW-1:0]    y_out,
  output logic signed [twsa_pkg::ANG_W-1:0] z_out,
  output logic [SIDE_W-1:0]                 side_out
);
  import twsa_pkg::*;

  logic [CORDIC_STEPS-1:0]  vld;
  logic signed [CW-1:0]     xr [CORDIC_STEPS];
  logic signed [CW-1:0]     yr [CORDIC_STEPS];
  logic signed [ANG_W-1:0]  zr [CORDIC_STEPS];
  logic [SIDE_W-1:0]        sr [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [CW-1:0]    xi, yi, xs, ys;
    logic signed [ANG_W-1:0] zi, at;
    logic [SIDE_W-1:0]       si;
    logic                    vi, sigma;

    if (g == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
      assign si = side_in;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = xr[g-1];
      assign yi = yr[g-1];
      assign zi = zr[g-1];
      assign si = sr[g-1];
      assign vi = vld[g-1];
    end

    assign xs    = xi >>> g;
    assign ys    = yi >>> g;
    assign at    = $signed(ANG_W'(ATAN_TAB[g]));
    // rotation steers by the residual angle, vectoring by the sign of y
    assign sigma = ROTATE ? !zi[ANG_W-1] : yi[CW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (sigma) begin
        xr[g] <= xi - ys;
        yr[g] <= yi + xs;
        zr[g] <= zi - at;
      end else begin
        xr[g] <= xi + ys;
        yr[g] <= yi - xs;
        zr[g] <= zi + at;
      end
      sr[g] <= si;
    end
  end

  assign out_valid = vld[CORDIC_STEPS-1];
  assign x_out     = xr[CORDIC_STEPS-1];
  assign y_out     = yr[CORDIC_STEPS-1];
  assign z_out     = zr[CORDIC_STEPS-1];
  assign side_out  = sr[CORDIC_STEPS-1];

endmodule

### hw/rtl/twsa_checker.sv
// ---------------------------------------------------------------------------
// twsa_checker
// Port-level checks of the terrain wind slope adjust block, bound to the top.
// ---------------------------------------------------------------------------
module twsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [14:0] direction_out
);
  import twsa_pkg::*;

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TWSA_LATENCY done)
    else $error("result missing after accepted word");

  // no result without a word accepted the latency before
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TWSA_LATENCY))
    else $error("result without matching word");

  // reset drops every word in flight
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (direction_out < DIR_UNITS))
    else $error("direction out of range");

endmodule

bind terrain_wind_slope_adjust twsa_checker u_twsa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .direction_out(direction_out)
);
